// ===== rtl/comvr_pkg.sv =====
package comvr_pkg;

  localparam int unsigned MassW = 16;
  localparam int unsigned VelW  = 32;
  localparam int unsigned SumW  = 28;
  localparam int unsigned MomW  = 60;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef enum logic {
    ACT_ACC = 1'b0,
    ACT_SUB = 1'b1
  } action_e;

  // one queued transaction
  typedef struct packed {
    action_e            action;
    logic               start_req;
    logic [MassW-1:0]   mass;
    logic [VelW-1:0]    vel_x;
    logic [VelW-1:0]    vel_y;
    logic [VelW-1:0]    vel_z;
  } item_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MUL,
    BK_DIV
  } back_state_e;

  // handshake between front queue and back end
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;

  function automatic logic [VelW-1:0] sat32(input logic signed [VelW:0] v, output logic s);
    logic [VelW-1:0] r;
    begin
      r = v[VelW-1:0];
      s = 1'b0;
      if (v[VelW] != v[VelW-1]) begin
        s = 1'b1;
        r = v[VelW] ? {1'b1, {(VelW-1){1'b0}}} : {1'b0, {(VelW-1){1'b1}}};
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/comvr_front.sv =====
module comvr_front
  import comvr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output q_ctrl_t ctrl_o,
  output logic    full_o,
  output item_t   item_o
);

  item_t       mem_q [QDepth];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign item_o       = mem_q[rd_q];
  assign ctrl_o.valid = (cnt_q != 2'd0);
  assign ctrl_o.pop   = pop_i;
  assign full_o       = (cnt_q == 2'(QDepth));

endmodule

// ===== rtl/comvr_div.sv =====
module comvr_div
  import comvr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   go_i,
  input  logic [MomW-1:0]        num_i,
  input  logic [SumW-1:0]        den_i,
  output logic                   done_o,
  output logic [VelW-1:0]        quo_o
);
  // restoring divide on magnitude, one quotient bit per cycle
  logic [MomW-1:0] mag_q, quo_q;
  logic [SumW:0]   rem_q;
  logic [5:0]      cnt_q;
  logic            neg_q, run_q;
  logic            done_q;
  logic [SumW:0]   trial;
  logic [SumW:0]   diff;
  logic signed [MomW:0] sq;
  logic [MomW-1:0] q_s;
  logic            dummy;

  assign trial = {rem_q[SumW-1:0], mag_q[MomW-1]};
  assign diff  = trial - {1'b0, den_i};

  // done pulses on the same edge that registers the last quotient bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'(MomW - 1);
      end else if (run_q) begin
        if (cnt_q == '0) run_q <= 1'b0;
        else cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      neg_q <= num_i[MomW-1];
      mag_q <= num_i[MomW-1] ? (~num_i + 1'b1) : num_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      mag_q <= {mag_q[MomW-2:0], 1'b0};
      if (!diff[SumW]) begin
        rem_q <= diff;
        quo_q <= {quo_q[MomW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[MomW-2:0], 1'b0};
      end
    end
  end

  assign q_s = neg_q ? (~quo_q + 1'b1) : quo_q;
  // quotient magnitude <= 2^59 fits; clamp into velocity range
  always_comb begin
    sq = {q_s[MomW-1], q_s};
    dummy = 1'b0;
    if ($signed(q_s) > $signed({{(MomW-VelW){1'b0}}, 1'b0, {(VelW-1){1'b1}}}))
      quo_o = {1'b0, {(VelW-1){1'b1}}};
    else if ($signed(q_s) < $signed({{(MomW-VelW+1){1'b1}}, {(VelW-1){1'b0}}}))
      quo_o = {1'b1, {(VelW-1){1'b0}}};
    else
      quo_o = sat32(sq[VelW:0], dummy);
  end
  assign done_o = done_q;

endmodule

// ===== rtl/comvr_back.sv =====
module comvr_back
  import comvr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_ctrl_t          ctrl_i,
  input  item_t            item_i,
  output logic             pop_o,
  output logic             idle_o,
  output logic             strobe_o,
  output logic [VelW-1:0]  new_x_o,
  output logic [VelW-1:0]  new_y_o,
  output logic [VelW-1:0]  new_z_o,
  output logic [1:0]       status_o
);

  back_state_e      st_q, st_d;
  logic [SumW-1:0]  msum_q;
  logic [MomW-1:0]  mom_q [3];
  logic [VelW-1:0]  cv_q  [3];
  logic             ready_q;
  logic [1:0]       ax_q, ax_d;
  logic signed [VelW+MassW:0] prod_q [3];
  logic             add_q;
  logic             clr_q;
  logic             div_go, div_done;
  logic [VelW-1:0]  div_quo;
  logic             pop;
  logic             sx, sy, sz;
  logic [VelW-1:0]  rx, ry, rz;

  // stage 1: multiply on pop of accumulate; stage 2 adds; a subtract may first run the divides
  always_comb begin
    st_d   = st_q;
    ax_d   = ax_q;
    pop    = 1'b0;
    div_go = 1'b0;
    case (st_q)
      BK_RUN: begin
        if (ctrl_i.valid) begin
          if (item_i.action == ACT_ACC) begin
            pop = 1'b1;
          end else if (add_q) begin
            pop = 1'b0;
          end else if (!ready_q && msum_q != '0) begin
            st_d   = BK_DIV;
            ax_d   = 2'd0;
            div_go = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end
      end
      BK_DIV: begin
        if (div_done) begin
          if (ax_q == 2'd2) st_d = BK_RUN;
          else begin
            ax_d   = ax_q + 2'd1;
            div_go = 1'b1;
          end
        end
      end
      default: st_d = BK_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= BK_RUN;
      ax_q     <= '0;
      add_q    <= 1'b0;
      clr_q    <= 1'b0;
      ready_q  <= 1'b0;
      strobe_o <= 1'b0;
      msum_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        mom_q[i] <= '0;
        cv_q[i]  <= '0;
      end
    end else begin
      st_q     <= st_d;
      ax_q     <= ax_d;
      strobe_o <= pop && item_i.action == ACT_SUB;
      add_q    <= pop && item_i.action == ACT_ACC;
      clr_q    <= item_i.start_req;
      if (pop && item_i.action == ACT_ACC) begin
        ready_q <= 1'b0;
        msum_q  <= (item_i.start_req ? '0 : msum_q) + SumW'(item_i.mass);
      end
      if (add_q) begin
        for (int i = 0; i < 3; i++)
          mom_q[i] <= (clr_q ? '0 : mom_q[i]) + MomW'(prod_q[i]);
      end
      if (div_done) cv_q[ax_q] <= div_quo;
      // last axis divided: center velocity is kept
      if (st_q == BK_DIV && div_done && ax_q == 2'd2) ready_q <= 1'b1;
      if (pop && item_i.action == ACT_SUB) begin
        ready_q  <= 1'b1;
        if (msum_q == '0) begin
          for (int i = 0; i < 3; i++) cv_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      prod_q[0] <= $signed(item_i.vel_x) * $signed({1'b0, item_i.mass});
      prod_q[1] <= $signed(item_i.vel_y) * $signed({1'b0, item_i.mass});
      prod_q[2] <= $signed(item_i.vel_z) * $signed({1'b0, item_i.mass});
    end
    if (pop && item_i.action == ACT_SUB) begin
      if (msum_q == '0) begin
        new_x_o  <= item_i.vel_x;
        new_y_o  <= item_i.vel_y;
        new_z_o  <= item_i.vel_z;
        status_o <= ST_ZERO;
      end else begin
        new_x_o  <= rx;
        new_y_o  <= ry;
        new_z_o  <= rz;
        status_o <= (sx | sy | sz) ? ST_SAT : ST_OK;
      end
    end
  end

  always_comb begin
    rx = sat32($signed({item_i.vel_x[VelW-1], item_i.vel_x})
             - $signed({cv_q[0][VelW-1], cv_q[0]}), sx);
    ry = sat32($signed({item_i.vel_y[VelW-1], item_i.vel_y})
             - $signed({cv_q[1][VelW-1], cv_q[1]}), sy);
    rz = sat32($signed({item_i.vel_z[VelW-1], item_i.vel_z})
             - $signed({cv_q[2][VelW-1], cv_q[2]}), sz);
  end

  comvr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (mom_q[ax_d]),
    .den_i  (msum_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign pop_o  = pop;
  assign idle_o = (st_q == BK_RUN) && !add_q && !ctrl_i.valid && ctrl_i.pop == 1'b0;

endmodule

// ===== rtl/center_of_mass_velocity_removal_unit.sv =====
// Channel  | Handshake              | Ports
// ---------+------------------------+----------------------------------------
// command  | start_i & !busy_o      | action_i start_req_i atom_mass_i vel_*_i
// result   | strobe_o (one cycle)   | new_x_o new_y_o new_z_o status_o
//
// Accumulate transactions retire one per cycle unless the back end is dividing;
// a subtract result is registered when the subtract leaves the queue, once the
// center velocity is kept. The first subtract after accumulation with a nonzero
// mass sum runs three divides, one per axis, on the shared bit-serial divider.
// A two-entry command queue raises busy_o while full; the receiver cannot stall.
// Reset clears the sums, the center velocity and the queue.
module center_of_mass_velocity_removal_unit
  import comvr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              action_i,
  input  logic              start_req_i,
  input  logic [MassW-1:0]  atom_mass_i,
  input  logic [VelW-1:0]   vel_x_i,
  input  logic [VelW-1:0]   vel_y_i,
  input  logic [VelW-1:0]   vel_z_i,
  output logic              strobe_o,
  output logic [VelW-1:0]   new_x_o,
  output logic [VelW-1:0]   new_y_o,
  output logic [VelW-1:0]   new_z_o,
  output logic [1:0]        status_o
);

  item_t   in_item, q_item;
  q_ctrl_t q_ctrl;
  logic    full, pop, push, idle;

  assign in_item.action    = action_e'(action_i);
  assign in_item.start_req = start_req_i;
  assign in_item.mass      = atom_mass_i;
  assign in_item.vel_x     = vel_x_i;
  assign in_item.vel_y     = vel_y_i;
  assign in_item.vel_z     = vel_z_i;

  assign busy_o = full;
  assign push   = start_i && !busy_o;

  comvr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item),
    .pop_i  (pop),
    .ctrl_o (q_ctrl),
    .full_o (full),
    .item_o (q_item)
  );

  comvr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (q_ctrl),
    .item_i   (q_item),
    .pop_o    (pop),
    .idle_o   (idle),
    .strobe_o (strobe_o),
    .new_x_o  (new_x_o),
    .new_y_o  (new_y_o),
    .new_z_o  (new_z_o),
    .status_o (status_o)
  );

  // a result never appears without a transaction leaving the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(pop)) else $error("result without pop");

  // status never reports an unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> status_o != 2'd3) else $error("bad status");

  // an idle back end has an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> !full) else $error("idle with full queue");

endmodule
